// ----- sv/skt_pkg.sv -----
// shared types and codes for the sorted key table
`default_nettype none
package skt_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_CLEAR    = 3'd1;
   localparam logic [2:0] CMD_INTERVAL = 3'd2;
   localparam logic [2:0] CMD_NEAREST  = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;
   localparam logic [2:0] CMD_WRITE    = 3'd5;
   localparam logic [2:0] CMD_RANGE    = 3'd6;
   localparam logic [2:0] CMD_SPAN     = 3'd7;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] y;
      logic signed [31:0] d;
   } entry_type;

   // scan record handed from cell to cell
   typedef struct packed {
      logic               act;
      logic               eq;
      logic signed [31:0] prev_key;
      entry_type          a;
      logic signed [31:0] b_key;
   } rec_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic signed [31:0] kx;
      logic signed [31:0] vy;
      logic signed [31:0] vd;
      logic               ins_go;
      logic               wr_go;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- sv/sorted_key_table_core.sv -----
// top level of the sorted key table: sequencer and chain of entry cells
`default_nettype none
// Sorted key table. Each request is one command on a table of up to TABLE_DEPTH
// entries (signed Q16.16 key with two values) kept in ascending key order, one entry
// per cell in a row of cells. The response is registered after the scan ends: a
// scan record enters the first cell and moves one cell per cycle, each cell adding
// its own key comparison and captures, so the row length sets the latency. An
// insert then shifts all higher entries up by one cell at once, each cell loading
// its left neighbor. One request is in flight at a time; req_ready is high only
// while the sequencer is idle, so a new request is accepted only after the last
// one has finished, and a response held by rsp_ready low stalls the next one in
// its finish step. No clearing pass is needed.
module sorted_key_table_core #(
   parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_cmd,
   input  wire logic signed [31:0] req_key_x,
   input  wire logic signed [31:0] req_value_y,
   input  wire logic signed [31:0] req_value_d,
   input  wire logic [7:0]         req_index_a,
   input  wire logic [7:0]         req_index_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [8:0]              rsp_position,
   output logic [8:0]              rsp_entry_count,
   output logic signed [31:0]      rsp_key_out,
   output logic signed [31:0]      rsp_last_key,
   output logic signed [31:0]      rsp_y_out,
   output logic signed [31:0]      rsp_d_out,
   output logic signed [32:0]      rsp_key_span
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_START  = 2'd1;
   localparam logic [1:0] S_SWEEP  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [2:0]          cmd_ff;
   logic signed [31:0]  kx_ff, vy_ff, vd_ff;
   logic [7:0]          ia_ff, ib_ff;
   skt_pkg::rec_type    tail_ff;
   logic [CW-1:0]       tail_le_ff, tail_near_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [8:0]          pos_ff, pos_in;
   logic [8:0]          cnt_out_ff, cnt_out_in;
   logic signed [31:0]  kout_ff, kout_in, klast_ff, klast_in;
   logic signed [31:0]  yout_ff, yout_in, dout_ff, dout_in;
   logic signed [32:0]  span_ff, span_in;

   skt_pkg::ctrl_type   ctrl;
   skt_pkg::rec_type    rec_head;
   logic [AW-1:0]       sel_a, sel_b, ia_w, ib_w, count_w;
   logic [CW-1:0]       ins_at, wr_at;
   logic                finish_go;

   skt_pkg::entry_type  ent [TABLE_DEPTH];
   skt_pkg::rec_type    rec [TABLE_DEPTH+1];
   logic [CW-1:0]       le_c [TABLE_DEPTH+1];
   logic [CW-1:0]       near_c [TABLE_DEPTH+1];

   assign req_ready = (state_ff == S_IDLE);
   assign finish_go = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign ia_w      = AW'(ia_ff);
   assign ib_w      = AW'(ib_ff);
   assign count_w   = AW'(count_ff);

   // key range reuses the two capture slots for first and last entries
   always_comb begin
      sel_a = ia_w;
      sel_b = ib_w;
      if (cmd_ff == skt_pkg::CMD_RANGE) begin
         sel_a = '0;
         sel_b = count_w - AW'(1);
      end
   end

   // scan record enters the first cell for one cycle
   always_comb begin
      rec_head     = '0;
      rec_head.act = (state_ff == S_START);
   end

   assign rec[0]    = rec_head;
   assign le_c[0]   = '0;
   assign near_c[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      skt_pkg::entry_type left_e;
      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_rest
         assign left_e = ent[i-1];
      end
      skt_cell #(.IDX(i), .CW(CW), .AW(AW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .sel_a      (sel_a),
         .sel_b      (sel_b),
         .ins_at     (ins_at),
         .wr_at      (wr_at),
         .left_entry (left_e),
         .entry      (ent[i]),
         .rec_in     (rec[i]),
         .le_in      (le_c[i]),
         .near_in    (near_c[i]),
         .rec_out    (rec[i+1]),
         .le_out     (le_c[i+1]),
         .near_out   (near_c[i+1])
      );
   end

   // result and commit decisions from the finished scan
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      pos_in       = pos_ff;
      cnt_out_in   = cnt_out_ff;
      kout_in      = kout_ff;
      klast_in     = klast_ff;
      yout_in      = yout_ff;
      dout_in      = dout_ff;
      span_in      = span_ff;
      ctrl.kx      = kx_ff;
      ctrl.vy      = vy_ff;
      ctrl.vd      = vd_ff;
      ctrl.ins_go  = 1'b0;
      ctrl.wr_go   = 1'b0;
      ins_at       = tail_le_ff;
      wr_at        = CW'(ia_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            // the record leaves the last cell
            if (rec[TABLE_DEPTH].act) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = skt_pkg::ST_OK;
               pos_in       = '0;
               kout_in      = '0;
               klast_in     = '0;
               yout_in      = '0;
               dout_in      = '0;
               span_in      = '0;
               case (cmd_ff)
                  skt_pkg::CMD_INSERT: begin
                     if (tail_ff.eq) begin
                        // equal key already held: overwrite its values
                        wr_at      = tail_le_ff - CW'(1);
                        ctrl.wr_go = 1'b1;
                        pos_in     = 9'(tail_le_ff - CW'(1));
                     end else if (count_ff >= FULL_COUNT) begin
                        status_in = skt_pkg::ST_FULL;
                     end else begin
                        ctrl.ins_go = 1'b1;
                        count_in    = count_ff + CW'(1);
                        pos_in      = 9'(tail_le_ff);
                     end
                  end
                  skt_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  skt_pkg::CMD_INTERVAL: begin
                     pos_in = 9'(tail_le_ff);
                  end
                  skt_pkg::CMD_NEAREST: begin
                     if (count_ff == '0) status_in = skt_pkg::ST_EMPTY;
                     else pos_in = 9'(tail_near_ff);
                  end
                  skt_pkg::CMD_READ, skt_pkg::CMD_WRITE: begin
                     if (ia_w >= count_w) begin
                        status_in = skt_pkg::ST_RANGE;
                     end else begin
                        kout_in = tail_ff.a.key;
                        yout_in = tail_ff.a.y;
                        dout_in = tail_ff.a.d;
                        if (cmd_ff == skt_pkg::CMD_WRITE) begin
                           ctrl.wr_go = 1'b1;
                           yout_in    = vy_ff;
                           dout_in    = vd_ff;
                        end
                     end
                  end
                  skt_pkg::CMD_RANGE: begin
                     if (count_ff == '0) begin
                        status_in = skt_pkg::ST_EMPTY;
                     end else begin
                        kout_in  = tail_ff.a.key;
                        klast_in = tail_ff.b_key;
                     end
                  end
                  default: begin
                     if ((ia_w >= count_w) || (ib_w >= count_w)) begin
                        status_in = skt_pkg::ST_RANGE;
                     end else begin
                        span_in = {tail_ff.b_key[31], tail_ff.b_key}
                                - {tail_ff.a.key[31], tail_ff.a.key};
                     end
                  end
               endcase
               cnt_out_in = 9'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         kx_ff  <= req_key_x;
         vy_ff  <= req_value_y;
         vd_ff  <= req_value_d;
         ia_ff  <= req_index_a;
         ib_ff  <= req_index_b;
      end
      if (rec[TABLE_DEPTH].act) begin
         tail_ff      <= rec[TABLE_DEPTH];
         tail_le_ff   <= le_c[TABLE_DEPTH];
         tail_near_ff <= near_c[TABLE_DEPTH];
      end
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      cnt_out_ff <= cnt_out_in;
      kout_ff    <= kout_in;
      klast_ff   <= klast_in;
      yout_ff    <= yout_in;
      dout_ff    <= dout_in;
      span_ff    <= span_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_key_out     = kout_ff;
   assign rsp_last_key    = klast_ff;
   assign rsp_y_out       = yout_ff;
   assign rsp_d_out       = dout_ff;
   assign rsp_key_span    = span_ff;

   // scan record reaches the end of the row only during a sweep
   a_tail_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rec[TABLE_DEPTH].act |-> (state_ff == S_SWEEP))
      else $error("scan record left the row outside a sweep");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_count_only_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> $stable(count_ff))
      else $error("entry count changed outside finish");

endmodule
`default_nettype wire

// ----- sv/skt_cell.sv -----
// one table cell: holds one entry and updates the passing scan record
`default_nettype none
module skt_cell #(
   parameter int IDX = 0,
   parameter int CW  = 9,
   parameter int AW  = 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire skt_pkg::ctrl_type  ctrl,
   input  wire logic [CW-1:0]      count,
   input  wire logic [AW-1:0]      sel_a,
   input  wire logic [AW-1:0]      sel_b,
   input  wire logic [CW-1:0]      ins_at,
   input  wire logic [CW-1:0]      wr_at,
   input  wire skt_pkg::entry_type left_entry,
   output skt_pkg::entry_type      entry,
   input  wire skt_pkg::rec_type   rec_in,
   input  wire logic [CW-1:0]      le_in,
   input  wire logic [CW-1:0]      near_in,
   output skt_pkg::rec_type        rec_out,
   output logic [CW-1:0]           le_out,
   output logic [CW-1:0]           near_out
);

   localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
   localparam logic [AW-1:0] MY_IDX_A = AW'(IDX);

   skt_pkg::entry_type entry_ff, entry_in;
   skt_pkg::rec_type   rec_ff, rec_in_n;
   logic [CW-1:0]      le_ff, le_in_n, near_ff, near_in_n;
   logic               live;
   logic signed [33:0] twice_k, mid_sum;

   assign live    = MY_IDX < count;
   assign twice_k = {ctrl.kx[31], ctrl.kx, 1'b0};
   assign mid_sum = {{2{rec_in.prev_key[31]}}, rec_in.prev_key}
                  + {{2{entry_ff.key[31]}}, entry_ff.key};

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_go && (MY_IDX > ins_at)) begin
         entry_in = left_entry;
      end else if (ctrl.ins_go && (MY_IDX == ins_at)) begin
         entry_in = '{key: ctrl.kx, y: ctrl.vy, d: ctrl.vd};
      end
      if (ctrl.wr_go && (MY_IDX == wr_at)) begin
         entry_in.y = ctrl.vy;
         entry_in.d = ctrl.vd;
      end
   end

   always_comb begin
      rec_in_n  = rec_in;
      le_in_n   = le_in;
      near_in_n = near_in;
      if (rec_in.act) begin
         rec_in_n.prev_key = entry_ff.key;
         if (live && (entry_ff.key <= ctrl.kx)) le_in_n = le_in + CW'(1);
         if (live && (IDX != 0) && (twice_k >= mid_sum)) near_in_n = near_in + CW'(1);
         if (live && (entry_ff.key == ctrl.kx)) rec_in_n.eq = 1'b1;
         if (MY_IDX_A == sel_a) rec_in_n.a = entry_ff;
         if (MY_IDX_A == sel_b) rec_in_n.b_key = entry_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      le_ff    <= le_in_n;
      near_ff  <= near_in_n;
      if (reset) rec_ff <= '0;
      else rec_ff <= rec_in_n;
   end

   assign entry    = entry_ff;
   assign rec_out  = rec_ff;
   assign le_out   = le_ff;
   assign near_out = near_ff;

endmodule
`default_nettype wire

// ----- tb/sorted_key_table_core_tb.sv -----
// self-checking testbench for the sorted key table core
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_core_tb;
   import skt_pkg::*;

   localparam int DEPTH       = 256;
   localparam int LATENCY     = DEPTH + 3;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] key_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_d;
      logic [7:0]         index_a;
      logic [7:0]         index_b;
   } request_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [8:0]         position;
      logic [8:0]         entry_count;
      logic signed [31:0] key_out;
      logic signed [31:0] last_key;
      logic signed [31:0] y_out;
      logic signed [31:0] d_out;
      logic signed [32:0] key_span;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_cmd = '0;
   logic signed [31:0] req_key_x = '0, req_value_y = '0, req_value_d = '0;
   logic [7:0] req_index_a = '0, req_index_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [8:0] rsp_position, rsp_entry_count;
   logic signed [31:0] rsp_key_out, rsp_last_key, rsp_y_out, rsp_d_out;
   logic signed [32:0] rsp_key_span;

   sorted_key_table_core #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_key_x(req_key_x), .req_value_y(req_value_y),
      .req_value_d(req_value_d), .req_index_a(req_index_a), .req_index_b(req_index_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_position(rsp_position),
      .rsp_entry_count(rsp_entry_count), .rsp_key_out(rsp_key_out),
      .rsp_last_key(rsp_last_key), .rsp_y_out(rsp_y_out), .rsp_d_out(rsp_d_out),
      .rsp_key_span(rsp_key_span)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the table, kept sorted by key
   entry_type   shadow_table [DEPTH];
   int unsigned shadow_count;

   request_type  pending_requests [$];
   response_type expected_responses [$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  recv_hold      = 1'b0;
   int  hold_cycles    = 0;
   bit  failed         = 1'b0;
   bit  req_taken      = 1'b0;
   longint cycle_count = 0;

   // number of stored keys at most k
   function automatic int unsigned keys_at_most(logic signed [31:0] k);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_table[mid].key <= k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // closest key, ties go to the higher index
   function automatic int unsigned closest_index(logic signed [31:0] k);
      int unsigned lo, hi, p;
      longint twice_mid;
      lo = 0;
      hi = shadow_count;
      while (hi - lo > 1) begin
         p = lo + (hi - lo) / 2;
         twice_mid = longint'(shadow_table[p-1].key) + longint'(shadow_table[p].key);
         if (2 * longint'(k) >= twice_mid) lo = p;
         else hi = p;
      end
      return lo;
   endfunction

   // apply one request to the shadow table and return its response
   function automatic response_type apply_request(request_type r);
      response_type rsp;
      int unsigned  slot;
      longint       diff;
      rsp = '0;
      case (r.cmd)
         CMD_INSERT: begin
            slot = keys_at_most(r.key_x);
            if (slot > 0 && shadow_table[slot-1].key == r.key_x) begin
               shadow_table[slot-1].y = r.value_y;
               shadow_table[slot-1].d = r.value_d;
               rsp.position = slot - 1;
            end else if (shadow_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > slot; i--)
                  shadow_table[i] = shadow_table[i-1];
               shadow_table[slot] = '{key: r.key_x, y: r.value_y, d: r.value_d};
               shadow_count++;
               rsp.position = slot;
            end
         end
         CMD_CLEAR: shadow_count = 0;
         CMD_INTERVAL: rsp.position = keys_at_most(r.key_x);
         CMD_NEAREST: begin
            if (shadow_count == 0) rsp.status = ST_EMPTY;
            else rsp.position = closest_index(r.key_x);
         end
         CMD_READ, CMD_WRITE: begin
            if (r.index_a >= shadow_count) begin
               rsp.status = ST_RANGE;
            end else begin
               if (r.cmd == CMD_WRITE) begin
                  shadow_table[r.index_a].y = r.value_y;
                  shadow_table[r.index_a].d = r.value_d;
               end
               rsp.key_out = shadow_table[r.index_a].key;
               rsp.y_out   = shadow_table[r.index_a].y;
               rsp.d_out   = shadow_table[r.index_a].d;
            end
         end
         CMD_RANGE: begin
            if (shadow_count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.key_out  = shadow_table[0].key;
               rsp.last_key = shadow_table[shadow_count-1].key;
            end
         end
         default: begin
            if (r.index_a >= shadow_count || r.index_b >= shadow_count) begin
               rsp.status = ST_RANGE;
            end else begin
               diff = longint'(shadow_table[r.index_b].key)
                    - longint'(shadow_table[r.index_a].key);
               rsp.key_span = diff[32:0];
            end
         end
      endcase
      rsp.entry_count = shadow_count[8:0];
      return rsp;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(0, 40)) << 16;
         default: return $urandom();
      endcase
   endfunction

   // indexes mostly land inside the held range, sometimes past it
   function automatic logic [7:0] rand_index(int unsigned held);
      if (held > 0 && $urandom_range(0, 9) < 8) return 8'($urandom_range(0, held - 1));
      return 8'($urandom());
   endfunction

   // driver: request fields change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the request until it is taken
         end else if (pending_requests.size() > 0
                      && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_cmd     <= pending_requests[0].cmd;
            req_key_x   <= pending_requests[0].key_x;
            req_value_y <= pending_requests[0].value_y;
            req_value_d <= pending_requests[0].value_d;
            req_index_a <= pending_requests[0].index_a;
            req_index_b <= pending_requests[0].index_b;
         end else begin
            req_valid <= 1'b0;
         end
         req_taken = 1'b0;
         if (recv_hold) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted in its own process
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         recv_hold   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         recv_hold <= 1'b0;
      end
   end

   // request side: predict at accept
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) begin
         expected_responses.push_back(apply_request(pending_requests.pop_front()));
         req_taken = 1'b1;
      end
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response, status %0d", rsp_status);
            failed = 1'b1;
         end else begin
            exp_rsp = expected_responses.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_position !== exp_rsp.position) begin
               $error("position: expected %0d, got %0d", exp_rsp.position, rsp_position);
               failed = 1'b1;
            end
            if (rsp_entry_count !== exp_rsp.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      exp_rsp.entry_count, rsp_entry_count);
               failed = 1'b1;
            end
            if (rsp_key_out !== exp_rsp.key_out) begin
               $error("key_out: expected %h, got %h", exp_rsp.key_out, rsp_key_out);
               failed = 1'b1;
            end
            if (rsp_last_key !== exp_rsp.last_key) begin
               $error("last_key: expected %h, got %h", exp_rsp.last_key, rsp_last_key);
               failed = 1'b1;
            end
            if (rsp_y_out !== exp_rsp.y_out) begin
               $error("y_out: expected %h, got %h", exp_rsp.y_out, rsp_y_out);
               failed = 1'b1;
            end
            if (rsp_d_out !== exp_rsp.d_out) begin
               $error("d_out: expected %h, got %h", exp_rsp.d_out, rsp_d_out);
               failed = 1'b1;
            end
            if (rsp_key_span !== exp_rsp.key_span) begin
               $error("key_span: expected %h, got %h", exp_rsp.key_span, rsp_key_span);
               failed = 1'b1;
            end
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_key_table_core_tb: FAIL");
         $finish;
      end
   end

   task automatic queue_request(logic [2:0] cmd, logic [31:0] kx, logic [31:0] vy,
                                logic [31:0] vd, logic [7:0] ia, logic [7:0] ib);
      request_type r;
      r = '{cmd: cmd, key_x: kx, value_y: vy, value_d: vd, index_a: ia, index_b: ib};
      pending_requests.push_back(r);
   endtask

   // model count tracked on the stimulus side to steer indexes
   int unsigned plan_count;

   task automatic queue_random(int n, int insert_bias);
      logic [2:0] cmd;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < insert_bias) cmd = CMD_INSERT;
         else if ($urandom_range(0, 60) == 0) cmd = CMD_CLEAR;
         else cmd = 3'($urandom_range(0, 7));
         if (cmd == CMD_INSERT && plan_count < DEPTH) plan_count++;
         if (cmd == CMD_CLEAR) plan_count = 0;
         queue_request(cmd, rand_word(), $urandom(), $urandom(),
                       rand_index(plan_count), rand_index(plan_count));
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int waited;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table cases, extremes, each command
      queue_request(CMD_NEAREST, 0, 0, 0, 0, 0);
      queue_request(CMD_RANGE, 0, 0, 0, 0, 0);
      queue_request(CMD_INTERVAL, 32'h7fff_ffff, 0, 0, 0, 0);
      queue_request(CMD_READ, 0, 0, 0, 0, 0);
      queue_request(CMD_WRITE, 0, 1, 2, 0, 0);
      queue_request(CMD_SPAN, 0, 0, 0, 0, 0);
      queue_request(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 0, 0);
      queue_request(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
      queue_request(CMD_INSERT, 32'h0001_0000, 32'h1234_5678, 32'h0, 0, 0);
      queue_request(CMD_INSERT, 32'h0001_0000, 32'hcafe_f00d, 32'h5555_aaaa, 0, 0);
      queue_request(CMD_SPAN, 0, 0, 0, 0, 2);
      queue_request(CMD_SPAN, 0, 0, 0, 2, 0);
      queue_request(CMD_SPAN, 0, 0, 0, 0, 3);
      queue_request(CMD_NEAREST, 32'h0000_8000, 0, 0, 0, 0);
      queue_request(CMD_NEAREST, 32'h8000_0000, 0, 0, 0, 0);
      queue_request(CMD_INTERVAL, 32'h8000_0000, 0, 0, 0, 0);
      queue_request(CMD_READ, 0, 0, 0, 1, 0);
      queue_request(CMD_WRITE, 0, 32'haaaa_5555, 32'h0f0f_f0f0, 2, 0);
      queue_request(CMD_READ, 0, 0, 0, 8'hff, 0);
      queue_request(CMD_RANGE, 0, 0, 0, 0, 0);
      queue_request(CMD_CLEAR, 0, 0, 0, 0, 0);
      queue_request(CMD_RANGE, 0, 0, 0, 0, 0);
      plan_count = 0;
      wait_drained();

      // fill the table to full, then insert new keys
      for (int i = 0; i < DEPTH; i++)
         queue_request(CMD_INSERT, 32'($urandom_range(0, 999)) * 1000 + 32'(i),
                       $urandom(), $urandom(), 0, 0);
      plan_count = DEPTH;
      queue_request(CMD_INSERT, 32'h7fff_fff0, 0, 0, 0, 0);
      queue_request(CMD_RANGE, 0, 0, 0, 0, 0);
      queue_request(CMD_SPAN, 0, 0, 0, 0, 8'hff);
      queue_random(40, 30);
      // long receiver hold-off while the sender keeps offering
      hold_cycles = 5 * LATENCY;
      wait_drained();
      queue_request(CMD_CLEAR, 0, 0, 0, 0, 0);
      plan_count = 0;

      // random phases with varied idling
      send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(70, 45); wait_drained();
      send_idle_pct = 72; recv_stall_pct = 0;  queue_random(70, 45); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 72; queue_random(70, 45); wait_drained();
      send_idle_pct = 11; recv_stall_pct = 11; queue_random(70, 45);
      hold_cycles = 3 * LATENCY;
      wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(60, 45); wait_drained();

      waited = 0;
      while (waited < 2 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      if (!failed && expected_responses.size() == 0) begin
         $display("sorted_key_table_core_tb: PASS");
      end else begin
         $display("sorted_key_table_core_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
